[rtl/core/bfts_pkg.sv]
// ----------------------------------------------------------------------------
// bfts_pkg
// Types and constants shared by the best-first tuple-sum enumerator.
// ----------------------------------------------------------------------------
package bfts_pkg;

  localparam int NUM_LISTS = 4;
  localparam int LIST_LEN  = 16;
  localparam int IDX_W     = 4;
  localparam int SCORE_W   = 16;
  localparam int SUM_W     = 18;
  localparam int SCORE_AW  = 6;
  localparam int SCORE_DEPTH = NUM_LISTS * LIST_LEN;
  localparam int TUPLE_W   = NUM_LISTS * IDX_W;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_NEXT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_HEAP_OVF = 2'd2;
  localparam logic [1:0] ST_VIS_OVF  = 2'd3;

  localparam logic [2:0] CFG_LIST_COUNT = 3'd0;
  localparam logic [2:0] CFG_LEN_0      = 3'd1;
  localparam logic [2:0] CFG_LEN_1      = 3'd2;
  localparam logic [2:0] CFG_LEN_2      = 3'd3;
  localparam logic [2:0] CFG_LEN_3      = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  list_select;
    logic [3:0]  entry_pos;
    logic [15:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index_0;
    logic [3:0]  index_1;
    logic [3:0]  index_2;
    logic [3:0]  index_3;
    logic [17:0] score_sum;
  } out_t;

  typedef struct packed {
    logic [2:0]                list_count;
    logic [NUM_LISTS-1:0][4:0] len;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_NEXT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [1:0]          sel;
    logic [IDX_W-1:0]    pos;
    logic [SCORE_W-1:0]  val;
  } req_t;

  typedef logic [NUM_LISTS-1:0][IDX_W-1:0] tuple_t;

  typedef enum logic [4:0] {
    BS_IDLE,
    BS_POP0,
    BS_POP1,
    BS_SD_V,
    BS_SD_L,
    BS_SD_LD,
    BS_SD_CV,
    BS_SD_RD,
    BS_SD_RV,
    BS_SD_CMP,
    BS_SD_SW,
    BS_SOLSUM,
    BS_SOL_DONE,
    BS_NB,
    BS_VS,
    BS_VS_CMP,
    BS_PUSH,
    BS_SU_V,
    BS_SU_P,
    BS_SU_PD,
    BS_SU_CMP,
    BS_SU_SW,
    BS_MARK,
    BS_SUM
  } bstate_e;

endpackage

[rtl/core/bfts_ram.sv]
// ----------------------------------------------------------------------------
// bfts_ram
// Simple dual-port RAM: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bfts_front.sv]
// ----------------------------------------------------------------------------
// bfts_front
// Accepts requests, decodes their kind and queues them for the back end.
// ----------------------------------------------------------------------------
module bfts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bfts_pkg::in_t in_data,
  output logic          q_valid,
  output bfts_pkg::req_t q_req,
  input  logic          q_pop
);
  import bfts_pkg::*;

  req_t       mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;
  req_t       dec;

  always_comb begin
    dec.sel = in_data.list_select;
    dec.pos = in_data.entry_pos;
    dec.val = in_data.entry_value;
    unique case (in_data.kind)
      KIND_LOAD:  dec.op = OP_LOAD;
      KIND_START: dec.op = OP_START;
      KIND_NEXT:  dec.op = OP_NEXT;
      default:    dec.op = OP_NONE;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop && q_valid) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= dec;
    end
  end

endmodule

[rtl/core/bfts_back.sv]
// ----------------------------------------------------------------------------
// bfts_back
// Sequencer that runs score loads, search starts and heap pops with
// neighbour expansion, and holds the result register.
// ----------------------------------------------------------------------------
module bfts_back #(
  parameter int HEAP_DEPTH    = 128,
  parameter int VISITED_DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bfts_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  bfts_pkg::req_t  q_req,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output bfts_pkg::out_t  out_data
);
  import bfts_pkg::*;

  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int HCW = $clog2(HEAP_DEPTH + 1);
  localparam int VAW = $clog2(VISITED_DEPTH);
  localparam int VCW = $clog2(VISITED_DEPTH + 1);

  bstate_e state_r, state_nxt, ret_r, ret_nxt;
  logic [HCW-1:0] hcnt_r, hcnt_nxt, i_r, i_nxt, c_r, c_nxt, par_r, par_nxt;
  logic [VCW-1:0] vcnt_r, vcnt_nxt, k_r, k_nxt;
  logic [1:0]     err_r, err_nxt;
  tuple_t         sol_r, sol_nxt, mv_r, mv_nxt, cand_r, cand_nxt;
  tuple_t         tc_r, tc_nxt, tr_r, tr_nxt, tp_r, tp_nxt, stup_r, stup_nxt;
  logic [SUM_W-1:0] v_r, v_nxt, cv_r, cv_nxt, ssum_r, ssum_nxt, acc_r, acc_nxt;
  logic [2:0]     sd_r, sd_nxt, nd_r, nd_nxt;
  logic           spend_r, spend_nxt, nj_r, nj_nxt;
  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [SCORE_DEPTH-1:0] svld_r, svld_nxt;
  logic           svld_rd_r;

  logic                h_we;
  logic [HAW-1:0]      h_waddr, h_raddr;
  tuple_t              h_wdata, h_rdata;
  logic                v_we;
  logic [VAW-1:0]      v_waddr, v_raddr;
  tuple_t              v_wdata, v_rdata;
  logic                s_we;
  logic [SCORE_AW-1:0] s_waddr, s_raddr;
  logic [SCORE_W-1:0]  s_wdata, s_rdata;

  logic [2:0]     n_w;
  logic [NUM_LISTS-1:0][4:0] lenc;
  logic [HCW:0]   l_w, r_w;
  logic [HCW-1:0] im1;
  logic [4:0]     cur_ix, new_ix, ev;
  tuple_t         nb_t;
  logic           nb_skip, inr, eq;
  out_t           ok_res;

  bfts_ram #(.WIDTH(TUPLE_W), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  bfts_ram #(.WIDTH(TUPLE_W), .DEPTH(VISITED_DEPTH)) u_vis (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  bfts_ram #(.WIDTH(SCORE_W), .DEPTH(SCORE_DEPTH)) u_score (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign n_w = (cfg.list_count > 3'd4) ? 3'd4 : cfg.list_count;
  assign l_w = {i_r, 1'b1};
  assign r_w = l_w + 1'b1;
  assign im1 = i_r - 1'b1;

  always_comb begin
    for (int d = 0; d < NUM_LISTS; d++) begin
      lenc[d] = (cfg.len[d] > 5'd16) ? 5'd16 : cfg.len[d];
    end
    cur_ix  = {1'b0, sol_r[nd_r[1:0]]};
    new_ix  = nj_r ? (cur_ix + 5'd1) : (cur_ix - 5'd1);
    nb_t    = sol_r;
    nb_t[nd_r[1:0]] = new_ix[IDX_W-1:0];
    inr     = 1'b1;
    for (int d = 0; d < NUM_LISTS; d++) begin
      ev = (2'(d) == nd_r[1:0]) ? new_ix : {1'b0, sol_r[d]};
      if ((3'(d) < n_w) && (ev >= lenc[d])) begin
        inr = 1'b0;
      end
    end
    nb_skip = (!nj_r && (cur_ix == 5'd0)) || !inr;
    eq = 1'b1;
    for (int d = 0; d < NUM_LISTS; d++) begin
      if ((3'(d) < n_w) && (v_rdata[d] != cand_r[d])) begin
        eq = 1'b0;
      end
    end
    ok_res           = '0;
    ok_res.status    = ST_OK;
    ok_res.index_0   = (n_w > 3'd0) ? sol_r[0] : '0;
    ok_res.index_1   = (n_w > 3'd1) ? sol_r[1] : '0;
    ok_res.index_2   = (n_w > 3'd2) ? sol_r[2] : '0;
    ok_res.index_3   = (n_w > 3'd3) ? sol_r[3] : '0;
    ok_res.score_sum = ssum_r;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    hcnt_nxt  = hcnt_r;
    vcnt_nxt  = vcnt_r;
    err_nxt   = err_r;
    i_nxt     = i_r;
    c_nxt     = c_r;
    par_nxt   = par_r;
    k_nxt     = k_r;
    sol_nxt   = sol_r;
    mv_nxt    = mv_r;
    cand_nxt  = cand_r;
    tc_nxt    = tc_r;
    tr_nxt    = tr_r;
    tp_nxt    = tp_r;
    stup_nxt  = stup_r;
    v_nxt     = v_r;
    cv_nxt    = cv_r;
    ssum_nxt  = ssum_r;
    acc_nxt   = acc_r;
    sd_nxt    = sd_r;
    spend_nxt = spend_r;
    nd_nxt    = nd_r;
    nj_nxt    = nj_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    svld_nxt  = svld_r;
    q_pop     = 1'b0;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;

    unique case (state_r)
      BS_IDLE: begin
        h_raddr = '0;
        if (q_valid && !out_valid_r) begin
          q_pop   = 1'b1;
          out_nxt = '0;
          unique case (q_req.op)
            OP_LOAD: begin
              s_we    = 1'b1;
              s_waddr = {q_req.sel, q_req.pos};
              s_wdata = q_req.val;
              svld_nxt[{q_req.sel, q_req.pos}] = 1'b1;
              out_valid_nxt = 1'b1;
            end
            OP_START: begin
              h_we     = 1'b1;
              v_we     = 1'b1;
              hcnt_nxt = HCW'(1);
              vcnt_nxt = VCW'(1);
              err_nxt  = ST_OK;
              out_valid_nxt = 1'b1;
            end
            OP_NEXT: begin
              if (err_r != ST_OK) begin
                out_nxt.status = err_r;
                out_valid_nxt  = 1'b1;
              end else if (hcnt_r == '0) begin
                out_nxt.status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = BS_POP0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BS_POP0: begin
        sol_nxt  = h_rdata;
        hcnt_nxt = hcnt_r - 1'b1;
        h_raddr  = hcnt_nxt[HAW-1:0];
        state_nxt = (hcnt_nxt == '0) ? BS_SOLSUM : BS_POP1;
      end
      BS_POP1: begin
        mv_nxt   = h_rdata;
        h_we     = 1'b1;
        h_waddr  = '0;
        h_wdata  = h_rdata;
        i_nxt    = '0;
        stup_nxt = h_rdata; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
        ret_nxt  = BS_SD_V;
        state_nxt = BS_SUM;
      end
      BS_SD_V: begin
        v_nxt = acc_r;
        state_nxt = BS_SD_L;
      end
      BS_SD_L: begin
        if (l_w >= {1'b0, hcnt_r}) begin
          state_nxt = BS_SOLSUM;
        end else begin
          h_raddr   = l_w[HAW-1:0];
          state_nxt = BS_SD_LD;
        end
      end
      BS_SD_LD: begin
        tc_nxt   = h_rdata;
        c_nxt    = l_w[HCW-1:0];
        stup_nxt = h_rdata; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
        ret_nxt  = BS_SD_CV;
        state_nxt = BS_SUM;
      end
      BS_SD_CV: begin
        cv_nxt = acc_r;
        if (r_w < {1'b0, hcnt_r}) begin
          h_raddr   = r_w[HAW-1:0];
          state_nxt = BS_SD_RD;
        end else begin
          state_nxt = BS_SD_CMP;
        end
      end
      BS_SD_RD: begin
        tr_nxt   = h_rdata;
        stup_nxt = h_rdata; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
        ret_nxt  = BS_SD_RV;
        state_nxt = BS_SUM;
      end
      BS_SD_RV: begin
        if (acc_r > cv_r) begin
          cv_nxt = acc_r;
          c_nxt  = r_w[HCW-1:0];
          tc_nxt = tr_r;
        end
        state_nxt = BS_SD_CMP;
      end
      BS_SD_CMP: begin
        if (cv_r <= v_r) begin
          state_nxt = BS_SOLSUM;
        end else begin
          h_we      = 1'b1;
          h_waddr   = i_r[HAW-1:0];
          h_wdata   = tc_r;
          state_nxt = BS_SD_SW;
        end
      end
      BS_SD_SW: begin
        h_we      = 1'b1;
        h_waddr   = c_r[HAW-1:0];
        h_wdata   = mv_r;
        i_nxt     = c_r;
        state_nxt = BS_SD_L;
      end
      BS_SOLSUM: begin
        stup_nxt = sol_r; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
        ret_nxt  = BS_SOL_DONE;
        state_nxt = BS_SUM;
      end
      BS_SOL_DONE: begin
        ssum_nxt  = acc_r;
        nd_nxt    = '0;
        nj_nxt    = 1'b0;
        state_nxt = BS_NB;
      end
      BS_NB: begin
        if (nd_r >= n_w) begin
          out_nxt       = ok_res;
          out_valid_nxt = 1'b1;
          state_nxt     = BS_IDLE;
        end else if (nb_skip) begin
          nj_nxt = ~nj_r;
          if (nj_r) begin
            nd_nxt = nd_r + 3'd1;
          end
        end else begin
          cand_nxt  = nb_t;
          k_nxt     = '0;
          state_nxt = BS_VS;
        end
      end
      BS_VS: begin
        if (k_r >= vcnt_r) begin
          state_nxt = BS_PUSH;
        end else begin
          v_raddr   = k_r[VAW-1:0];
          k_nxt     = k_r + 1'b1;
          state_nxt = BS_VS_CMP;
        end
      end
      BS_VS_CMP: begin
        if (eq) begin
          nj_nxt = ~nj_r;
          if (nj_r) begin
            nd_nxt = nd_r + 3'd1;
          end
          state_nxt = BS_NB;
        end else begin
          state_nxt = BS_VS;
        end
      end
      BS_PUSH: begin
        if (hcnt_r >= HCW'(HEAP_DEPTH)) begin
          err_nxt        = ST_HEAP_OVF;
          out_nxt        = '0;
          out_nxt.status = ST_HEAP_OVF;
          out_valid_nxt  = 1'b1;
          state_nxt      = BS_IDLE;
        end else begin
          h_we     = 1'b1;
          h_waddr  = hcnt_r[HAW-1:0];
          h_wdata  = cand_r;
          i_nxt    = hcnt_r;
          hcnt_nxt = hcnt_r + 1'b1;
          stup_nxt = cand_r; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
          ret_nxt  = BS_SU_V;
          state_nxt = BS_SUM;
        end
      end
      BS_SU_V: begin
        v_nxt = acc_r;
        state_nxt = BS_SU_P;
      end
      BS_SU_P: begin
        if (i_r == '0) begin
          state_nxt = BS_MARK;
        end else begin
          par_nxt   = {1'b0, im1[HCW-1:1]};
          h_raddr   = par_nxt[HAW-1:0];
          state_nxt = BS_SU_PD;
        end
      end
      BS_SU_PD: begin
        tp_nxt   = h_rdata;
        stup_nxt = h_rdata; sd_nxt = '0; spend_nxt = 1'b0; acc_nxt = '0;
        ret_nxt  = BS_SU_CMP;
        state_nxt = BS_SUM;
      end
      BS_SU_CMP: begin
        if (v_r <= acc_r) begin
          state_nxt = BS_MARK;
        end else begin
          h_we      = 1'b1;
          h_waddr   = i_r[HAW-1:0];
          h_wdata   = tp_r;
          state_nxt = BS_SU_SW;
        end
      end
      BS_SU_SW: begin
        h_we      = 1'b1;
        h_waddr   = par_r[HAW-1:0];
        h_wdata   = cand_r;
        i_nxt     = par_r;
        state_nxt = BS_SU_P;
      end
      BS_MARK: begin
        if (vcnt_r >= VCW'(VISITED_DEPTH)) begin
          err_nxt        = ST_VIS_OVF;
          out_nxt        = '0;
          out_nxt.status = ST_VIS_OVF;
          out_valid_nxt  = 1'b1;
          state_nxt      = BS_IDLE;
        end else begin
          v_we     = 1'b1;
          v_waddr  = vcnt_r[VAW-1:0];
          v_wdata  = cand_r;
          vcnt_nxt = vcnt_r + 1'b1;
          nj_nxt   = ~nj_r;
          if (nj_r) begin
            nd_nxt = nd_r + 3'd1;
          end
          state_nxt = BS_NB;
        end
      end
      BS_SUM: begin
        acc_nxt = acc_r + ((spend_r && svld_rd_r) ? SUM_W'(s_rdata) : '0);
        if (sd_r < n_w) begin
          s_raddr   = {sd_r[1:0], stup_r[sd_r[1:0]]};
          sd_nxt    = sd_r + 3'd1;
          spend_nxt = 1'b1;
        end else if (spend_r) begin
          spend_nxt = 1'b0;
        end else begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      ret_r       <= BS_IDLE;
      hcnt_r      <= '0;
      vcnt_r      <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
      svld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      hcnt_r      <= hcnt_nxt;
      vcnt_r      <= vcnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      svld_r      <= svld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    c_r       <= c_nxt;
    par_r     <= par_nxt;
    k_r       <= k_nxt;
    sol_r     <= sol_nxt;
    mv_r      <= mv_nxt;
    cand_r    <= cand_nxt;
    tc_r      <= tc_nxt;
    tr_r      <= tr_nxt;
    tp_r      <= tp_nxt;
    stup_r    <= stup_nxt;
    v_r       <= v_nxt;
    cv_r      <= cv_nxt;
    ssum_r    <= ssum_nxt;
    acc_r     <= acc_nxt;
    sd_r      <= sd_nxt;
    spend_r   <= spend_nxt;
    nd_r      <= nd_nxt;
    nj_r      <= nj_nxt;
    out_r     <= out_nxt;
    svld_rd_r <= svld_r[s_raddr];
  end

endmodule

[rtl/core/best_first_tuple_sum_enumerator.sv]
// ----------------------------------------------------------------------------
// best_first_tuple_sum_enumerator
// Yields index tuples over up to four score lists in descending order of
// their summed scores, using a binary max-heap and a visited list.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake        Payload
//   in_       input      valid / stall    bfts_pkg::in_t
//   out_      output     valid / stall    bfts_pkg::out_t
//   cfg_      input      valid / ready    3-bit index, 5-bit data
//
// A load, start or unused request is answered straight from the idle state
// once it leaves the two-entry input queue. A next request pops the heap
// top and sifts down, then for each of up to eight neighbours runs a linear
// visited search and pushes and sifts up any new tuple; every score sum reads
// one list at a time through the single score read port, and the visited
// search and that port set the speed. There is no clearing pass after reset.
// Requests are queued while a result is stalled.
// ----------------------------------------------------------------------------
module best_first_tuple_sum_enumerator #(
  parameter int HEAP_DEPTH    = 128,
  parameter int VISITED_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bfts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bfts_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [4:0]     cfg_data
);
  import bfts_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_pop;
  req_t q_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.list_count <= 3'd3;
      cfg_r.len        <= {NUM_LISTS{5'd16}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIST_COUNT: cfg_r.list_count <= cfg_data[2:0];
        CFG_LEN_0:      cfg_r.len[0] <= cfg_data;
        CFG_LEN_1:      cfg_r.len[1] <= cfg_data;
        CFG_LEN_2:      cfg_r.len[2] <= cfg_data;
        CFG_LEN_3:      cfg_r.len[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bfts_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  bfts_back #(.HEAP_DEPTH(HEAP_DEPTH), .VISITED_DEPTH(VISITED_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[rtl/core/bfts_chk.sv]
// ----------------------------------------------------------------------------
// bfts_chk
// Port-level checks for the tuple-sum enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module bfts_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input bfts_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input bfts_pkg::out_t out_data,
  input logic           cfg_valid,
  input logic           cfg_ready,
  input logic [2:0]     cfg_index,
  input logic [4:0]     cfg_data
);
  import bfts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.score_sum == '0) && (out_data.index_0 == '0) &&
      (out_data.index_1 == '0) && (out_data.index_2 == '0) &&
      (out_data.index_3 == '0))
    else $error("error result carries a tuple");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind best_first_tuple_sum_enumerator bfts_chk u_bfts_chk (.*);
